@@ sv/ros_pkg.sv @@
package ros_pkg;

    localparam int DW      = 32;
    localparam int FB      = 20;
    localparam int NK      = 6;
    localparam int NROW    = NK + 1;
    localparam int KW      = $clog2(NK);
    localparam int RK4_NK  = 4;
    localparam int CFG_AW  = 2;

    // comb unit: products, rounding, one add per term, h product, rounding, final add
    localparam int COMB_LAT  = NK + 5;
    // derivative unit: products, rounding, three saturating adds
    localparam int DER_LAT   = 5;

    localparam logic [CFG_AW-1:0] REG_DAMPING   = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_STIFFNESS = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_RELAY     = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_METHOD    = CFG_AW'(3);

    typedef logic signed [DW-1:0]   t_word;
    typedef logic signed [2*DW-1:0] t_prod;
    typedef t_word [NK-1:0]         t_row;

    typedef struct packed {
        t_word x;
        t_word v;
        t_word h;
        logic  s_pos;
        logic  s_neg;
        logic  ov;
        t_word px;
        t_word pv;
        t_row  kx;
        t_row  kv;
    } t_item;

    typedef struct packed {
        logic  ov;
        t_word val;
    } t_sat;

    localparam t_word MAXW = {1'b0, {(DW-1){1'b1}}};
    localparam t_word MINW = {1'b1, {(DW-1){1'b0}}};
    localparam t_word ZW   = '0;

    localparam logic [2*DW-1:0] RND  = (2*DW)'(1) << (FB - 1);
    localparam logic [2*DW-1:0] LIMP = {{DW{1'b0}}, MAXW};
    localparam logic [2*DW-1:0] LIMN = LIMP + (2*DW)'(1);

    // tableau constants, num/den rounded to nearest at FB, half away from zero
    localparam longint SC = longint'(1) <<< (FB + 1);

    localparam t_word C_1_2   = t_word'((1 * SC + 2) / 4);
    localparam t_word C_1     = t_word'((1 * SC + 1) / 2);
    localparam t_word C_1_6   = t_word'((1 * SC + 6) / 12);
    localparam t_word C_1_3   = t_word'((1 * SC + 3) / 6);

    localparam t_word D_21    = t_word'((1 * SC + 5) / 10);
    localparam t_word D_31    = t_word'((3 * SC + 40) / 80);
    localparam t_word D_32    = t_word'((9 * SC + 40) / 80);
    localparam t_word D_41    = t_word'((44 * SC + 45) / 90);
    localparam t_word D_42    = t_word'(-((56 * SC + 15) / 30));
    localparam t_word D_43    = t_word'((32 * SC + 9) / 18);
    localparam t_word D_51    = t_word'((19372 * SC + 6561) / 13122);
    localparam t_word D_52    = t_word'(-((25360 * SC + 2187) / 4374));
    localparam t_word D_53    = t_word'((64448 * SC + 6561) / 13122);
    localparam t_word D_54    = t_word'(-((212 * SC + 729) / 1458));
    localparam t_word D_61    = t_word'((9017 * SC + 3168) / 6336);
    localparam t_word D_62    = t_word'(-((355 * SC + 33) / 66));
    localparam t_word D_63    = t_word'((46732 * SC + 5247) / 10494);
    localparam t_word D_64    = t_word'((49 * SC + 176) / 352);
    localparam t_word D_65    = t_word'(-((5103 * SC + 18656) / 37312));
    localparam t_word D_W1    = t_word'((35 * SC + 384) / 768);
    localparam t_word D_W3    = t_word'((500 * SC + 1113) / 2226);
    localparam t_word D_W4    = t_word'((125 * SC + 192) / 384);
    localparam t_word D_W5    = t_word'(-((2187 * SC + 6784) / 13568));
    localparam t_word D_W6    = t_word'((11 * SC + 84) / 168);

    // rows 0..NK-1 feed the stages, the last row holds the weights; term 0 is rightmost
    localparam t_row RK4_ROWS [NROW] = '{
        {ZW, ZW, ZW, ZW, ZW, ZW},
        {ZW, ZW, ZW, ZW, ZW, C_1_2},
        {ZW, ZW, ZW, ZW, C_1_2, ZW},
        {ZW, ZW, ZW, C_1, ZW, ZW},
        {ZW, ZW, ZW, ZW, ZW, ZW},
        {ZW, ZW, ZW, ZW, ZW, ZW},
        {ZW, ZW, C_1_6, C_1_3, C_1_3, C_1_6}
    };

    localparam t_row DP_ROWS [NROW] = '{
        {ZW, ZW, ZW, ZW, ZW, ZW},
        {ZW, ZW, ZW, ZW, ZW, D_21},
        {ZW, ZW, ZW, ZW, D_32, D_31},
        {ZW, ZW, ZW, D_43, D_42, D_41},
        {ZW, ZW, D_54, D_53, D_52, D_51},
        {ZW, D_65, D_64, D_63, D_62, D_61},
        {D_W6, D_W5, D_W4, D_W3, ZW, D_W1}
    };

    function automatic t_sat sat_add(t_word a, t_word b);
        logic signed [DW:0] s;
        t_sat r;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            r.ov  = 1'b1;
            r.val = s[DW] ? MINW : MAXW;
        end else begin
            r.ov  = 1'b0;
            r.val = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic t_sat sat_sub(t_word a, t_word b);
        logic signed [DW:0] s;
        t_sat r;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            r.ov  = 1'b1;
            r.val = s[DW] ? MINW : MAXW;
        end else begin
            r.ov  = 1'b0;
            r.val = s[DW-1:0];
        end
        return r;
    endfunction

    // round magnitude half away from zero at FB, then saturate
    function automatic t_sat mul_round(t_prod p);
        logic            neg;
        logic [2*DW-1:0] mag;
        logic [2*DW-1:0] q;
        t_sat            r;
        neg = p[2*DW-1];
        mag = neg ? (2*DW)'(~p + 1'b1) : (2*DW)'(p);
        q   = (mag + RND) >> FB;
        if (q > (neg ? LIMN : LIMP)) begin
            r.ov  = 1'b1;
            r.val = neg ? MINW : MAXW;
        end else begin
            r.ov  = 1'b0;
            r.val = neg ? t_word'(~q[DW-1:0] + 1'b1) : t_word'(q[DW-1:0]);
        end
        return r;
    endfunction

endpackage

@@ sv/ros_comb.sv @@
module ros_comb (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  ros_pkg::t_item i_ctx,
    input  ros_pkg::t_row  i_coef,
    output logic          o_vld,
    output ros_pkg::t_item o_ctx
);
    import ros_pkg::*;

    localparam int SH = NK + 2;   // h product stage
    localparam int SR = NK + 3;   // h rounding stage
    localparam int SF = NK + 4;   // final add stage

    logic [COMB_LAT-1:0] r_vld;
    t_item r_ctx [COMB_LAT];
    t_item n_ctx [COMB_LAT];
    t_prod r_mx [NK];
    t_prod r_mv [NK];
    t_prod n_mx [NK];
    t_prod n_mv [NK];
    t_row  r_tx [NK];
    t_row  r_tv [NK];
    t_row  n_tx [NK];
    t_row  n_tv [NK];
    t_word r_ax [NK];
    t_word r_av [NK];
    t_word n_ax [NK];
    t_word n_av [NK];
    t_prod r_hx, r_hv, n_hx, n_hv;
    t_word r_hxr, r_hvr, n_hxr, n_hvr;

    always_comb begin
        t_sat sx;
        t_sat sv;
        n_ctx[0] = i_ctx;
        for (int s = 1; s < COMB_LAT; s++) begin
            n_ctx[s] = r_ctx[s-1];
        end
        // products of coefficient and slope
        for (int j = 0; j < NK; j++) begin
            n_mx[j] = $signed(i_coef[j]) * $signed(i_ctx.kx[j]);
            n_mv[j] = $signed(i_coef[j]) * $signed(i_ctx.kv[j]);
        end
        // rounding
        for (int j = 0; j < NK; j++) begin
            sx = mul_round(r_mx[j]);
            sv = mul_round(r_mv[j]);
            n_tx[0][j] = sx.val;
            n_tv[0][j] = sv.val;
            n_ctx[1].ov = n_ctx[1].ov | sx.ov | sv.ov;
        end
        // one saturating add per stage, from term 0 upward
        for (int k = 0; k < NK; k++) begin
            sx = sat_add((k == 0) ? ZW : r_ax[(k == 0) ? 0 : k-1], r_tx[k][k]);
            sv = sat_add((k == 0) ? ZW : r_av[(k == 0) ? 0 : k-1], r_tv[k][k]);
            n_ax[k] = sx.val;
            n_av[k] = sv.val;
            n_ctx[2+k].ov = n_ctx[2+k].ov | sx.ov | sv.ov;
            if (k < NK - 1) begin
                n_tx[k+1] = r_tx[k];
                n_tv[k+1] = r_tv[k];
            end
        end
        // scale by step size
        n_hx = r_ctx[SH-1].h * r_ax[NK-1];
        n_hv = r_ctx[SH-1].h * r_av[NK-1];
        sx = mul_round(r_hx);
        sv = mul_round(r_hv);
        n_hxr = sx.val;
        n_hvr = sv.val;
        n_ctx[SR].ov = n_ctx[SR].ov | sx.ov | sv.ov;
        // offset from the start point
        sx = sat_add(r_ctx[SF-1].x, r_hxr);
        sv = sat_add(r_ctx[SF-1].v, r_hvr);
        n_ctx[SF].px = sx.val;
        n_ctx[SF].pv = sv.val;
        n_ctx[SF].ov = n_ctx[SF].ov | sx.ov | sv.ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[COMB_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= n_ctx;
            r_mx  <= n_mx;
            r_mv  <= n_mv;
            r_tx  <= n_tx;
            r_tv  <= n_tv;
            r_ax  <= n_ax;
            r_av  <= n_av;
            r_hx  <= n_hx;
            r_hv  <= n_hv;
            r_hxr <= n_hxr;
            r_hvr <= n_hvr;
        end
    end

    assign o_vld = r_vld[COMB_LAT-1];
    assign o_ctx = r_ctx[COMB_LAT-1];

endmodule

@@ sv/ros_deriv.sv @@
module ros_deriv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  ros_pkg::t_item      i_ctx,
    input  ros_pkg::t_word      i_b,
    input  ros_pkg::t_word      i_c,
    input  ros_pkg::t_word      i_d,
    input  logic [ros_pkg::KW-1:0] i_row,
    input  logic                i_active,
    output logic                o_vld,
    output ros_pkg::t_item      o_ctx
);
    import ros_pkg::*;

    logic [DER_LAT-1:0] r_vld;
    t_item r_ctx [DER_LAT];
    t_item n_ctx [DER_LAT];
    t_prod r_bv, r_cx, n_bv, n_cx;
    t_word r_bvr, r_cxr, r_cxr2, r_acc2, r_acc3;
    t_word n_bvr, n_cxr, n_acc2, n_acc3;

    always_comb begin
        t_sat sa;
        t_sat sb;
        t_sat nd;
        n_ctx[0] = i_ctx;
        for (int s = 1; s < DER_LAT; s++) begin
            n_ctx[s] = r_ctx[s-1];
        end
        n_bv = i_b * i_ctx.pv;
        n_cx = i_c * i_ctx.px;
        sa = mul_round(r_bv);
        sb = mul_round(r_cx);
        n_bvr = sa.val;
        n_cxr = sb.val;
        n_ctx[1].ov = n_ctx[1].ov | (i_active & (sa.ov | sb.ov));
        sa = sat_sub(ZW, r_bvr);
        n_acc2 = sa.val;
        n_ctx[2].ov = n_ctx[2].ov | (i_active & sa.ov);
        sa = sat_sub(r_acc2, r_cxr2);
        n_acc3 = sa.val;
        n_ctx[3].ov = n_ctx[3].ov | (i_active & sa.ov);
        // relay term: d, nothing or the negated gain
        nd = sat_sub(ZW, i_d);
        sa = sat_add(r_acc3, r_ctx[3].s_neg ? nd.val : i_d);
        n_ctx[4].kx[i_row] = r_ctx[3].pv;
        if (r_ctx[3].s_pos) begin
            n_ctx[4].kv[i_row] = sa.val;
            n_ctx[4].ov = n_ctx[4].ov | (i_active & sa.ov);
        end else if (r_ctx[3].s_neg) begin
            n_ctx[4].kv[i_row] = sa.val;
            n_ctx[4].ov = n_ctx[4].ov | (i_active & (sa.ov | nd.ov));
        end else begin
            n_ctx[4].kv[i_row] = r_acc3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DER_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx  <= n_ctx;
            r_bv   <= n_bv;
            r_cx   <= n_cx;
            r_bvr  <= n_bvr;
            r_cxr  <= n_cxr;
            r_cxr2 <= r_cxr;
            r_acc2 <= n_acc2;
            r_acc3 <= n_acc3;
        end
    end

    assign o_vld = r_vld[DER_LAT-1];
    assign o_ctx = r_ctx[DER_LAT-1];

endmodule

@@ sv/relay_oscillator_rk_step_core.sv @@
// One explicit Runge-Kutta step of x'' = -b x' - c x + d sign(x_delayed) in signed
// Q11.20 with saturation. The core takes one beat per cycle while its output is not
// stalled; a beat passes through six slope stages (each a combination unit followed
// by a derivative unit), the weight combination and the output register. RK4 runs
// through the same six stages with zero tableau entries, and the two extra stages
// cannot raise overflow then. The output register lets the pipeline keep taking
// beats while a result waits. Write configuration only while no beat is in flight.
module relay_oscillator_rk_step_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ros_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [ros_pkg::DW-1:0]        i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // position, velocity, delayed_position, step_size
    input  logic [4*ros_pkg::DW-1:0]      s_axis_tdata,
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // next_position, next_velocity
    output logic [2*ros_pkg::DW-1:0]      m_axis_tdata,
    // overflow
    output logic                          m_axis_tuser
);
    import ros_pkg::*;

    t_word r_b, r_c, r_d;
    logic  r_method;

    t_item w_in;
    t_item w_ctx [NK+1];
    logic  w_vld [NK+1];
    t_item w_mid [NK];
    logic  w_mid_vld [NK];
    t_row  w_coef [NROW];
    t_item w_last;
    logic  w_last_vld;
    logic  w_en;

    logic  r_out_vld;
    t_word r_out_x, r_out_v;
    logic  r_out_ov;

    t_word w_xd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b      <= '0;
            r_c      <= '0;
            r_d      <= '0;
            r_method <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DAMPING:   r_b      <= i_cfg_data;
                REG_STIFFNESS: r_c      <= i_cfg_data;
                REG_RELAY:     r_d      <= i_cfg_data;
                REG_METHOD:    r_method <= i_cfg_data[0];
                default:       r_method <= r_method;
            endcase
        end
    end

    // unpack the input beat, sign of the delayed position is taken once here
    assign w_xd = s_axis_tdata[3*DW-1:2*DW];

    always_comb begin
        w_in       = '0;
        w_in.x     = s_axis_tdata[DW-1:0];
        w_in.v     = s_axis_tdata[2*DW-1:DW];
        w_in.h     = s_axis_tdata[4*DW-1:3*DW];
        w_in.s_pos = ~w_xd[DW-1] & (|w_xd);
        w_in.s_neg = w_xd[DW-1];
        w_in.ov    = 1'b0;
        w_in.px    = w_in.x;
        w_in.pv    = w_in.v;
    end

    // whole pipeline moves unless its last stage holds a beat the output can't take
    assign w_en          = !w_last_vld || !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_ctx[0] = w_in;
    assign w_vld[0] = s_axis_tvalid;

    for (genvar r = 0; r < NROW; r++) begin : g_coef
        assign w_coef[r] = r_method ? DP_ROWS[r] : RK4_ROWS[r];
    end

    // slope stages: stage input point, then its derivative
    for (genvar r = 0; r < NK; r++) begin : g_stage
        ros_comb u_comb (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[r]),
            .i_ctx   (w_ctx[r]),
            .i_coef  (w_coef[r]),
            .o_vld   (w_mid_vld[r]),
            .o_ctx   (w_mid[r])
        );

        ros_deriv u_deriv (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_vld    (w_mid_vld[r]),
            .i_ctx    (w_mid[r]),
            .i_b      (r_b),
            .i_c      (r_c),
            .i_d      (r_d),
            .i_row    (KW'(r)),
            .i_active (r_method | ((r < RK4_NK) ? 1'b1 : 1'b0)),
            .o_vld    (w_vld[r+1]),
            .o_ctx    (w_ctx[r+1])
        );
    end

    // weighted sum of the slopes gives the result point
    ros_comb u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[NK]),
        .i_ctx   (w_ctx[NK]),
        .i_coef  (w_coef[NK]),
        .o_vld   (w_last_vld),
        .o_ctx   (w_last)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= w_last_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || m_axis_tready) begin
            r_out_x  <= w_last.px;
            r_out_v  <= w_last.pv;
            r_out_ov <= w_last.ov;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_v, r_out_x};
    assign m_axis_tuser  = r_out_ov;

    // input stalls only when both the last stage and the output register are full
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_last_vld && r_out_vld && !m_axis_tready))
        else $error("input stalled without a full output");

    // a result beat appears only from a valid last pipeline stage
    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_last_vld))
        else $error("result beat without a pipeline beat");

    // reset empties the output
    a_reset_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// checks the relay oscillator step core against a bit-true fixed point predictor:
// random phases of coefficients and method, random input and output idling, every
// result beat compared field by field with the oldest expected step
module tb_top;

    import ros_pkg::*;

    localparam longint MAX_Q = 64'sd2147483647;
    localparam longint MIN_Q = -64'sd2147483648;
    // cycles to wait after draining, with margin over the pipeline depth
    localparam int DRAIN_CYCLES = 160;
    localparam int CYCLE_LIMIT  = 2000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_index;
    logic [DW-1:0]     i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [4*DW-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [2*DW-1:0]   m_axis_tdata;
    logic              m_axis_tuser;

    typedef struct {
        t_word pos;
        t_word vel;
        t_word dly;
        t_word h;
    } t_step_in;

    typedef struct {
        t_word nx;
        t_word nv;
        bit    ov;
    } t_step_out;

    t_step_in  pending_steps[$];
    t_step_out expected_steps[$];

    // predictor copy of the registers
    longint damp_b, stiff_c, gain_d;
    bit     use_dopri;
    bit     sat_flag;

    int  errors;
    int  cycles;
    bit  in_took;
    bit  quiet;
    int  send_gap;
    int  recv_gap;

    relay_oscillator_rk_step_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // butcher tableaus as numerator / denominator pairs
    int rk4_an[4][3] = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
    int rk4_ad[4][3] = '{'{1, 1, 1}, '{2, 1, 1}, '{1, 2, 1}, '{1, 1, 1}};
    int rk4_wn[4]    = '{1, 1, 1, 1};
    int rk4_wd[4]    = '{6, 3, 3, 6};
    int dp_an[6][5]  = '{'{0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0}, '{3, 9, 0, 0, 0},
                         '{44, -56, 32, 0, 0}, '{19372, -25360, 64448, -212, 0},
                         '{9017, -355, 46732, 49, -5103}};
    int dp_ad[6][5]  = '{'{1, 1, 1, 1, 1}, '{5, 1, 1, 1, 1}, '{40, 40, 1, 1, 1},
                         '{45, 15, 9, 1, 1}, '{6561, 2187, 6561, 729, 1},
                         '{3168, 33, 5247, 176, 18656}};
    int dp_wn[6]     = '{35, 0, 500, 125, -2187, 11};
    int dp_wd[6]     = '{384, 1, 1113, 192, 6784, 84};

    function automatic longint clamp_q(longint v);
        if (v > MAX_Q) begin
            sat_flag = 1'b1;
            return MAX_Q;
        end
        if (v < MIN_Q) begin
            sat_flag = 1'b1;
            return MIN_Q;
        end
        return v;
    endfunction

    function automatic longint add_q(longint a, longint b);
        return clamp_q(a + b);
    endfunction

    function automatic longint sub_q(longint a, longint b);
        return clamp_q(a - b);
    endfunction

    // product rounded half away from zero at the fraction point, then saturated
    function automatic longint mul_q(longint a, longint b);
        bit     neg;
        longint mag;
        longint q;
        longint lim;
        neg = (a < 0) != (b < 0);
        mag = a * b;
        if (mag < 0) mag = -mag;
        q   = (mag + (64'sd1 <<< (FB - 1))) >>> FB;
        lim = neg ? MAX_Q + 1 : MAX_Q;
        if (q > lim) begin
            sat_flag = 1'b1;
            return neg ? MIN_Q : MAX_Q;
        end
        return neg ? -q : q;
    endfunction

    function automatic longint tableau_q(int num, int den);
        longint mag;
        longint dd;
        longint q;
        longint r;
        mag = (num < 0) ? -longint'(num) : longint'(num);
        dd  = (den > 0) ? longint'(den) : 64'sd1;
        q   = (mag <<< FB) / dd;
        r   = (mag <<< FB) % dd;
        if (2 * r >= dd) q++;
        if (q > MAX_Q) q = MAX_Q;
        return (num < 0) ? -q : q;
    endfunction

    // accel = ((0 - b*v) - c*x) + d*sign
    function automatic longint accel_q(longint x, longint v, int sgn);
        longint acc;
        acc = sub_q(0, mul_q(damp_b, v));
        acc = sub_q(acc, mul_q(stiff_c, x));
        if (sgn > 0) acc = add_q(acc, gain_d);
        else if (sgn < 0) acc = add_q(acc, sub_q(0, gain_d));
        return acc;
    endfunction

    function automatic t_step_out rk_step(t_step_in st);
        longint    x, v, xd, h, ax, av, px, pv, a;
        longint    kx[6];
        longint    kv[6];
        int        sgn, nst;
        t_step_out r;
        x  = longint'(st.pos);
        v  = longint'(st.vel);
        xd = longint'(st.dly);
        h  = longint'(st.h);
        sgn = (xd > 0) ? 1 : ((xd < 0) ? -1 : 0);
        nst = use_dopri ? 6 : 4;
        sat_flag = 1'b0;
        for (int i = 0; i < nst; i++) begin
            px = x;
            pv = v;
            if (i > 0) begin
                ax = 0;
                av = 0;
                for (int j = 0; j < i; j++) begin
                    a  = use_dopri ? tableau_q(dp_an[i][j], dp_ad[i][j])
                                   : tableau_q(rk4_an[i][j], rk4_ad[i][j]);
                    ax = add_q(ax, mul_q(a, kx[j]));
                    av = add_q(av, mul_q(a, kv[j]));
                end
                px = add_q(x, mul_q(h, ax));
                pv = add_q(v, mul_q(h, av));
            end
            kx[i] = pv;
            kv[i] = accel_q(px, pv, sgn);
        end
        ax = 0;
        av = 0;
        for (int i = 0; i < nst; i++) begin
            a  = use_dopri ? tableau_q(dp_wn[i], dp_wd[i]) : tableau_q(rk4_wn[i], rk4_wd[i]);
            ax = add_q(ax, mul_q(a, kx[i]));
            av = add_q(av, mul_q(a, kv[i]));
        end
        r.nx = t_word'(add_q(x, mul_q(h, ax)));
        r.nv = t_word'(add_q(v, mul_q(h, av)));
        r.ov = sat_flag;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input stream and receiver backpressure driver, changes at the falling edge
    always @(negedge i_clk) begin
        logic       nxt_valid;
        logic [4*DW-1:0] nxt_data;
        t_step_in   st;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (in_took) nxt_valid = 1'b0;
        if (!nxt_valid && pending_steps.size() > 0) begin
            if (send_gap > 0) begin
                send_gap--;
            end else begin
                st        = pending_steps.pop_front();
                nxt_data  = {st.h, st.dly, st.vel, st.pos};
                nxt_valid = 1'b1;
                send_gap  = quiet ? 0 : idle_len();
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
        // receiver backpressure
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            recv_gap = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        end
    end

    // accepted input beats feed the predictor, result beats are checked here
    always @(posedge i_clk) begin
        t_step_in  st;
        t_step_out ex;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
        in_took = s_axis_tvalid && s_axis_tready && i_rst_n;
        if (in_took) begin
            st.pos = s_axis_tdata[DW-1:0];
            st.vel = s_axis_tdata[2*DW-1:DW];
            st.dly = s_axis_tdata[3*DW-1:2*DW];
            st.h   = s_axis_tdata[4*DW-1:3*DW];
            expected_steps.insert(expected_steps.size(), rk_step(st));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_steps.size() == 0) begin
                errors++;
                $error("result beat with no step outstanding");
            end else begin
                ex = expected_steps.pop_front();
                if (m_axis_tdata[DW-1:0] !== ex.nx) begin
                    errors++;
                    $error("next_position expected %0d got %0d", ex.nx,
                           $signed(m_axis_tdata[DW-1:0]));
                end
                if (m_axis_tdata[2*DW-1:DW] !== ex.nv) begin
                    errors++;
                    $error("next_velocity expected %0d got %0d", ex.nv,
                           $signed(m_axis_tdata[2*DW-1:DW]));
                end
                if (m_axis_tuser !== ex.ov) begin
                    errors++;
                    $error("overflow expected %0d got %0d", ex.ov, m_axis_tuser);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_DAMPING:   damp_b    = longint'($signed(data));
            REG_STIFFNESS: stiff_c   = longint'($signed(data));
            REG_RELAY:     gain_d    = longint'($signed(data));
            REG_METHOD:    use_dopri = data[0];
            default: ;
        endcase
    endtask

    task automatic set_coeffs(t_word b, t_word c, t_word d, logic [DW-1:0] meth);
        write_reg(REG_DAMPING, b);
        write_reg(REG_STIFFNESS, c);
        write_reg(REG_RELAY, d);
        write_reg(REG_METHOD, meth);
    endtask

    // hold the sender until every result is back, then let the pipe empty
    task automatic drain();
        wait (pending_steps.size() == 0 && !s_axis_tvalid && expected_steps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_step(t_word x, t_word v, t_word xd, t_word h);
        t_step_in st;
        st.pos = x;
        st.vel = v;
        st.dly = xd;
        st.h   = h;
        pending_steps.insert(pending_steps.size(), st);
    endtask

    // mostly moderate magnitudes so the step stays out of saturation
    function automatic t_word rand_word(int frac_span);
        if ($urandom_range(0, 4) == 0) return t_word'($urandom());
        return t_word'($signed($urandom_range(0, (1 << frac_span) - 1)) - (1 << (frac_span - 1)));
    endfunction

    function automatic t_word rand_step();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return ZW;
        if (roll == 1) return t_word'($urandom());
        return rand_word(18);
    endfunction

    function automatic t_word rand_coeff();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return MAXW;
        if (roll == 1) return MINW;
        if (roll == 2) return ZW;
        return rand_word(23);
    endfunction

    initial begin
        t_word one;
        one = t_word'(1 << FB);
        errors = 0;
        cycles = 0;
        in_took = 1'b0;
        quiet = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        damp_b = 0;
        stiff_c = 0;
        gain_d = 0;
        use_dopri = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: pure drift x + h*v
        queue_step(one, one, ZW, one >>> 4);
        queue_step(MAXW, MAXW, MAXW, MAXW);
        drain();

        // unit oscillator, zero step, extremes and all three relay signs, both schemes
        for (int m = 0; m < 2; m++) begin
            set_coeffs(one >>> 3, one, one >>> 1, m ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
            queue_step(one, ZW, one, ZW);
            queue_step(MAXW, MINW, MINW, ZW);
            queue_step(one, one >>> 1, one, one >>> 5);
            queue_step(one, one >>> 1, -one, one >>> 5);
            queue_step(one, one >>> 1, ZW, one >>> 5);
            queue_step(MAXW, MAXW, one, one >>> 5);
            queue_step(MINW, MINW, -one, -(one >>> 5));
            queue_step(one, -one, one, MAXW);
            queue_step(-one, one, MINW, MINW);
            drain();
        end

        // most negative relay gain, negated when the delayed sign is negative
        set_coeffs(ZW, one, MINW, 32'd1);
        queue_step(one, one, -one, one >>> 6);
        queue_step(one, one, one, one >>> 6);
        drain();

        for (int p = 0; p < 8; p++) begin
            quiet = (p == 3);
            case (p)
                1:       set_coeffs(MAXW, MAXW, MAXW, 32'd1);
                2:       set_coeffs(MINW, MINW, MINW, 32'd0);
                default: set_coeffs(rand_coeff(), rand_coeff(), rand_coeff(), $urandom());
            endcase
            for (int n = 0; n < 100; n++) begin
                queue_step(rand_word(22), rand_word(22),
                           ($urandom_range(0, 5) == 0) ? ZW : t_word'($urandom()), rand_step());
            end
            drain();
        end
        quiet = 1'b0;

        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
